@@ sv/midpoint_displacement_terrain_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the terrain generator
// Shared concurrent assertion forms, all clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_DISPLACEMENT_TERRAIN_MACROS_SVH
`define MIDPOINT_DISPLACEMENT_TERRAIN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define MDT_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ sv/mdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Terrain generator package
// Grid geometry, payload types, memory request bundle and address helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

    // Grid geometry: (2^GRID_LOG + 1) points on a side.
    localparam int GRID_LOG   = 8;
    localparam int GRID_LAST  = 1 << GRID_LOG;
    localparam int GRID_N     = GRID_LAST + 1;
    localparam int GRID_DEPTH = GRID_N * GRID_N;
    localparam int COORD_W    = GRID_LOG + 1;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int HEIGHT_W   = 12;
    localparam int PHASE_W    = 4;

    // Field widths and constants of the channels.
    localparam int RAND_W     = 9;
    localparam int OUT_W      = 8;
    localparam int SEA_W      = 9;
    localparam int SEA_RESET  = 144;
    localparam int CORNER_SUB = 255;
    localparam int OUT_MAX    = 159;

    // Command codes.
    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [COORD_W-1:0]         coord_t;
    typedef logic [ADDR_W-1:0]          grid_addr_t;
    typedef logic signed [HEIGHT_W-1:0] height_t;

    typedef struct packed {
        logic              command;
        logic [RAND_W-1:0] random_bits;
        logic [OUT_W-1:0]  col_x;
        logic [OUT_W-1:0]  row_y;
    } mdt_in_t;

    typedef struct packed {
        logic       ready_res;
        logic [5:0] height;
        logic [3:0] colour;
    } mdt_out_t;

    // Memory accesses requested by the fill controller.
    typedef struct packed {
        grid_addr_t rd_addr_a;
        grid_addr_t rd_addr_b;
        grid_addr_t wr_addr;
        height_t    wr_data;
    } mdt_ram_req_t;

    // Linear address of point (x,y): x * GRID_N + y as shift and add.
    function automatic grid_addr_t grid_addr(input coord_t x, input coord_t y);
        return (grid_addr_t'(x) << GRID_LOG) + grid_addr_t'(x) + grid_addr_t'(y);
    endfunction

endpackage

`default_nettype wire

@@ sv/mdt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_ram #(
    parameter int WIDTH = mdt_pkg::HEIGHT_W,
    parameter int DEPTH = mdt_pkg::GRID_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports.
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

@@ sv/mdt_fill_ctl.sv @@
// ----------------------------------------------------------------------------
// Fill controller
// Walks the midpoint displacement order, issues the neighbor reads and
// forms the value written back in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_displacement_terrain_macros.svh"

module mdt_fill_ctl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic [mdt_pkg::RAND_W-1:0]  random_bits,
    input  wire mdt_pkg::height_t            rd_data_a,
    input  wire mdt_pkg::height_t            rd_data_b,
    output mdt_pkg::mdt_ram_req_t            ram_req,
    output logic                             grid_done
);

    import mdt_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               pass_reg, pass_next;
    coord_t             x_reg, x_next;
    coord_t             y_reg, y_next;
    logic               done_reg, done_next;
    logic               corner_reg;
    logic signed [9:0]  disp_reg;
    grid_addr_t         wr_addr_reg;

    coord_t             step;
    logic [COORD_W:0]   step2;
    logic [COORD_W:0]   x_plus2, y_plus2, x_plus1;
    coord_t             ax, ay, bx, by, cx, cy;
    logic [RAND_W-1:0]  rnd_masked;
    logic signed [9:0]  disp, corner_val;
    logic signed [12:0] sum, half, wr_val;

    // Half step of the current phase and its double.
    always_comb begin
        step  = coord_t'(1) << (GRID_LOG - int'(phase_reg));
        step2 = {1'b0, step} << 1;
    end

    // Neighbor coordinates for the current point.
    always_comb begin
        if (pass_reg == 1'b0) begin
            ax = x_reg - step;
            ay = y_reg;
            bx = x_reg + step;
            by = y_reg;
        end else begin
            ax = x_reg;
            ay = y_reg - step;
            bx = x_reg;
            by = y_reg + step;
        end
        cx = x_reg[1] ? coord_t'(GRID_LAST) : '0;
        cy = x_reg[0] ? coord_t'(GRID_LAST) : '0;
    end

    // Displacement (r & (2s-1)) - (s-1), and the corner value r - 255.
    always_comb begin
        rnd_masked = random_bits & RAND_W'(step2 - 1'b1);
        disp       = $signed({1'b0, rnd_masked}) - $signed({1'b0, step - 1'b1});
        corner_val = $signed({1'b0, random_bits}) - 10'sd255;
    end

    // Next position in the fill order.
    always_comb begin
        phase_next = phase_reg;
        pass_next  = pass_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        done_next  = done_reg;
        x_plus2    = {1'b0, x_reg} + step2;
        y_plus2    = {1'b0, y_reg} + step2;
        x_plus1    = {1'b0, x_reg} + {1'b0, step};
        if (phase_reg == '0) begin
            // Corners.
            if (x_reg == coord_t'(3)) begin
                phase_next = PHASE_W'(1);
                pass_next  = 1'b0;
                x_next     = coord_t'(GRID_LAST / 2);
                y_next     = '0;
            end else begin
                x_next = x_reg + 1'b1;
            end
        end else if (pass_reg == 1'b0) begin
            // Row pass.
            if (x_plus2 > (COORD_W + 1)'(GRID_LAST)) begin
                x_next = step;
                if (y_plus2 > (COORD_W + 1)'(GRID_LAST)) begin
                    pass_next = 1'b1;
                    x_next    = '0;
                    y_next    = step;
                end else begin
                    y_next = y_plus2[COORD_W-1:0];
                end
            end else begin
                x_next = x_plus2[COORD_W-1:0];
            end
        end else begin
            // Column pass.
            if (y_plus2 > (COORD_W + 1)'(GRID_LAST)) begin
                y_next = step;
                if (x_plus1 > (COORD_W + 1)'(GRID_LAST)) begin
                    if (phase_reg >= PHASE_W'(GRID_LOG)) begin
                        done_next = 1'b1;
                        x_next    = '0;
                        y_next    = '0;
                    end else begin
                        phase_next = phase_reg + 1'b1;
                        pass_next  = 1'b0;
                        x_next     = step >> 1;
                        y_next     = '0;
                    end
                end else begin
                    x_next = x_plus1[COORD_W-1:0];
                end
            end else begin
                y_next = y_plus2[COORD_W-1:0];
            end
        end
    end

    // Position state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            pass_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            done_reg  <= 1'b0;
        end else if (advance && !done_reg) begin
            phase_reg <= phase_next;
            pass_reg  <= pass_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            done_reg  <= done_next;
        end
    end

    // Target and displacement held for the write cycle.
    always_ff @(posedge aclk) begin
        if (advance) begin
            corner_reg  <= (phase_reg == '0);
            disp_reg    <= (phase_reg == '0) ? corner_val : disp;
            wr_addr_reg <= (phase_reg == '0) ? grid_addr(cx, cy) : grid_addr(x_reg, y_reg);
        end
    end

    // Average truncated toward zero plus displacement.
    always_comb begin
        sum    = $signed({rd_data_a[HEIGHT_W-1], rd_data_a})
               + $signed({rd_data_b[HEIGHT_W-1], rd_data_b});
        half   = (sum + $signed({12'b0, sum[12]})) >>> 1;
        wr_val = half + $signed({{3{disp_reg[9]}}, disp_reg});
    end

    always_comb begin
        ram_req.rd_addr_a = grid_addr(ax, ay);
        ram_req.rd_addr_b = grid_addr(bx, by);
        ram_req.wr_addr   = wr_addr_reg;
        ram_req.wr_data   = corner_reg ? height_t'({{2{disp_reg[9]}}, disp_reg})
                                       : wr_val[HEIGHT_W-1:0];
    end

    assign grid_done = done_reg;

    `MDT_ASSERT_IMPLY(a_done_last_phase, aclk, aresetn, done_reg, phase_reg == PHASE_W'(GRID_LOG), "grid done before the last phase")
    `MDT_ASSERT_IMPLY(a_pos_in_grid, aclk, aresetn, 1'b1, (x_reg <= coord_t'(GRID_LAST)) && (y_reg <= coord_t'(GRID_LAST)), "fill position outside the grid")
    `MDT_ASSERT_NEXT(a_corner_exit, aclk, aresetn, advance && (phase_reg == '0) && (x_reg == coord_t'(3)), (phase_reg == PHASE_W'(1)) && (x_reg == coord_t'(GRID_LAST / 2)) && !pass_reg, "corners did not hand over to the first row pass")

endmodule

`default_nettype wire

@@ sv/midpoint_displacement_terrain.sv @@
// ----------------------------------------------------------------------------
// Midpoint displacement terrain generator
// Builds a height grid one point per fill request and answers sampled,
// shaded reads of it.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry requests. command CMD_FILL consumes one
//   random word and fills the next grid point; it produces no result.
//   command CMD_READ samples the grid at (8*col_x/5, 8*row_y/5) and returns
//   one result on m_valid/m_ready/m_data (height, colour, ready_res).
//   cfg_valid/cfg_ready/cfg_data write the sea level offset; cfg_ready is
//   always high, and the offset should change only while the block is idle.
//   A fill reads both neighbors through the two read ports of the grid
//   memory, then writes the new point; no request is taken during the write.
//   A read passes through address, memory read, offset and clamp, and
//   scaling before its result reaches m_valid; reads do not overlap, and
//   the next read is taken only after the result has been taken.
//   While a result waits on m_ready, fills are still accepted; a new read
//   waits until the output register is empty.
//   Reset returns the fill order to the corners, clears the flag shown as ready_res and sets
//   the offset to 144. The grid memory is not cleared: reads of points not
//   yet generated return unspecified values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_displacement_terrain_macros.svh"

module midpoint_displacement_terrain (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire mdt_pkg::mdt_in_t           s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output mdt_pkg::mdt_out_t               m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mdt_pkg::SEA_W-1:0]  cfg_data
);

    import mdt_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL_WR = 3'd1;
    localparam logic [2:0] ST_RD_ADDR = 3'd2;
    localparam logic [2:0] ST_RD_DATA = 3'd3;
    localparam logic [2:0] ST_RD_CALC = 3'd4;

    // floor(n/5) = (n * 1639) >> 13 for the n used here, and
    // floor(v/12) = (v * 2731) >> 15 for any 12-bit v.
    localparam int SCALE_MUL   = 1639;
    localparam int SCALE_SHIFT = 13;
    localparam int SHADE_MUL   = 2731;
    localparam int SHADE_SHIFT = 15;

    logic [2:0]        state_reg, state_next;
    logic [SEA_W-1:0]  sea_reg;
    logic [OUT_W-1:0]  sx_reg, sy_reg;
    logic [11:0]       v_reg;
    logic              m_valid_reg;
    mdt_out_t          m_data_reg;

    logic              s_fire, advance, rd_fire, grid_done, ram_we;
    logic [OUT_W-1:0]  cx_cl, cy_cl, sx, sy;
    logic [20:0]       prod_x, prod_y;
    grid_addr_t        ram_rd_addr_a;
    height_t           rd_data_a, rd_data_b;
    mdt_ram_req_t      ram_req;
    logic signed [12:0] vsum;
    logic [23:0]       prod_v;
    logic [8:0]        h_full, c_full;
    mdt_out_t          result;

    // Request handshake.
    always_comb begin
        s_ready = (state_reg == ST_IDLE)
               && ((s_data.command == CMD_FILL) || !m_valid_reg);
        s_fire  = s_valid && s_ready;
        advance = s_fire && (s_data.command == CMD_FILL) && !grid_done;
        rd_fire = s_fire && (s_data.command == CMD_READ);
        ram_we  = (state_reg == ST_FILL_WR);
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (advance) begin
                    state_next = ST_FILL_WR;
                end else if (rd_fire) begin
                    state_next = ST_RD_ADDR;
                end
            end
            ST_FILL_WR: state_next = ST_IDLE;
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_RD_CALC;
            ST_RD_CALC: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sea level offset register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sea_reg <= SEA_W'(SEA_RESET);
        end else if (cfg_valid) begin
            sea_reg <= cfg_data;
        end
    end

    // Read coordinates: clamp, then scale by 8/5.
    always_comb begin
        cx_cl  = (s_data.col_x > OUT_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : s_data.col_x;
        cy_cl  = (s_data.row_y > OUT_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : s_data.row_y;
        prod_x = 21'({cx_cl, 3'b000}) * 21'(SCALE_MUL);
        prod_y = 21'({cy_cl, 3'b000}) * 21'(SCALE_MUL);
        sx     = OUT_W'(prod_x >> SCALE_SHIFT);
        sy     = OUT_W'(prod_y >> SCALE_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (rd_fire) begin
            sx_reg <= sx;
            sy_reg <= sy;
        end
    end

    // Grid memory and fill controller.
    assign ram_rd_addr_a = (state_reg == ST_RD_ADDR)
                         ? grid_addr(coord_t'(sx_reg), coord_t'(sy_reg))
                         : ram_req.rd_addr_a;

    mdt_fill_ctl u_fill_ctl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .random_bits (s_data.random_bits),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .ram_req     (ram_req),
        .grid_done   (grid_done)
    );

    mdt_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid_ram (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_req.wr_addr),
        .wr_data   (ram_req.wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (ram_req.rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Add the sea offset and clamp negatives to zero.
    assign vsum = $signed({rd_data_a[HEIGHT_W-1], rd_data_a}) + $signed({4'b0, sea_reg});

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_DATA) begin
            v_reg <= vsum[12] ? '0 : vsum[11:0];
        end
    end

    // Height and colour from the clamped value.
    always_comb begin
        prod_v = 24'(v_reg) * 24'(SHADE_MUL);
        h_full = 9'(prod_v >> SHADE_SHIFT);
        c_full = (h_full >> 1) + 9'd3;
        result.ready_res = grid_done;
        result.height    = (h_full > 9'd63) ? 6'd63 : h_full[5:0];
        if ((c_full == 9'd3) && (h_full != '0)) begin
            result.colour = 4'd4;
        end else if (c_full > 9'd15) begin
            result.colour = 4'd15;
        end else begin
            result.colour = c_full[3:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_RD_CALC) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_CALC) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MDT_ASSERT_NEXT(a_fill_writes, aclk, aresetn, advance, state_reg == ST_FILL_WR, "fill request not followed by a write")
    `MDT_ASSERT_IMPLY(a_slot_free, aclk, aresetn, state_reg == ST_RD_CALC, !m_valid_reg, "read result would overwrite a pending result")
    `MDT_ASSERT_AFTER(a_read_latency, aclk, aresetn, rd_fire, 4, m_valid_reg, "read result missing four cycles after the request")

endmodule

`default_nettype wire
